// File: sv/aar_pkg.sv
// Shared types, constants and arithmetic helpers for the axis-angle rotation matrix block.
`timescale 1ns / 1ps
`default_nettype none
package aar_pkg;

  // Fixed-point formats of the ports and of the internal Q30 words
  localparam int IN_FRAC_BITS  = 12;
  localparam int OUT_FRAC_BITS = 14;
  localparam int ANG_SHIFT     = 30 - IN_FRAC_BITS;
  localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;

  // Rotation steps and the length of each cell chain
  localparam int STEPS = 30;
  localparam int NCELL = 31;

  typedef logic signed [33:0] q_t;

  localparam q_t Q30_ONE     = 34'sd1073741824;
  localparam q_t PI_Q30      = 34'sd3373259426;
  localparam q_t TWO_PI_Q30  = 34'sd6746518852;
  localparam q_t HALF_PI_Q30 = 34'sd1686629713;
  localparam q_t GAIN_Q30    = 34'sd652032874;

  // Word moving along the rotation and square-root chain
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic               neg;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic [4:0]         h;
    q_t                 cx;
    q_t                 sy;
    q_t                 zr;
    logic [62:0]        num;
    logic [62:0]        res;
  } rot_t;

  // Word moving along the divider chain
  typedef struct packed {
    logic              vld;
    logic              zero;
    q_t                c;
    q_t                s;
    logic [30:0]       root;
    logic [2:0]        sgn;
    logic [2:0][61:0]  rem;
    logic [2:0][30:0]  quo;
  } div_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic q_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    return 34'sd843314857;
      5'd1:    return 34'sd497837829;
      5'd2:    return 34'sd263043837;
      5'd3:    return 34'sd133525159;
      5'd4:    return 34'sd67021687;
      5'd5:    return 34'sd33543516;
      5'd6:    return 34'sd16775851;
      5'd7:    return 34'sd8388437;
      5'd8:    return 34'sd4194283;
      5'd9:    return 34'sd2097149;
      5'd10:   return 34'sd1048576;
      5'd11:   return 34'sd524288;
      5'd12:   return 34'sd262144;
      5'd13:   return 34'sd131072;
      5'd14:   return 34'sd65536;
      5'd15:   return 34'sd32768;
      5'd16:   return 34'sd16384;
      5'd17:   return 34'sd8192;
      5'd18:   return 34'sd4096;
      5'd19:   return 34'sd2048;
      5'd20:   return 34'sd1024;
      5'd21:   return 34'sd512;
      5'd22:   return 34'sd256;
      5'd23:   return 34'sd128;
      5'd24:   return 34'sd64;
      5'd25:   return 34'sd32;
      5'd26:   return 34'sd16;
      5'd27:   return 34'sd8;
      5'd28:   return 34'sd4;
      5'd29:   return 34'sd2;
      default: return '0;
    endcase
  endfunction

  // Clamp a Q30 word to plus or minus one
  function automatic q_t clamp_one(input q_t v);
    if (v > Q30_ONE) return Q30_ONE;
    if (v < -Q30_ONE) return -Q30_ONE;
    return v;
  endfunction

  // Q30 product, rounded half up
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
    return q_t'(p >>> 30);
  endfunction

  // Round a Q30 word to the output format and saturate
  function automatic logic signed [15:0] to_out(input q_t v);
    q_t r;
    r = (v + (34'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > (34'sd1 <<< OUT_FRAC_BITS)) r = 34'sd1 <<< OUT_FRAC_BITS;
    if (r < -(34'sd1 <<< OUT_FRAC_BITS)) r = -(34'sd1 <<< OUT_FRAC_BITS);
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/aar_front.sv
// Front stages: angle reduction, squared axis length and its normalising shift.
`timescale 1ns / 1ps
`default_nettype none
module aar_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] in_angle,
  input  wire logic signed [15:0] in_axis_x,
  input  wire logic signed [15:0] in_axis_y,
  input  wire logic signed [15:0] in_axis_z,
  output aar_pkg::rot_t           f_out
);
  import aar_pkg::*;

  rot_t f1_r, f1_nxt;
  rot_t f2_r, f2_nxt;
  rot_t f3_r, f3_nxt;

  // Stage one: remainder by two pi, squared length
  always_comb begin
    q_t                 ang;
    logic signed [31:0] px, py, pz;
    logic [31:0]        n2;
    ang = q_t'(in_angle) <<< ANG_SHIFT;
    px  = in_axis_x * in_axis_x;
    py  = in_axis_y * in_axis_y;
    pz  = in_axis_z * in_axis_z;
    n2  = unsigned'(px) + unsigned'(py) + unsigned'(pz);
    f1_nxt      = '0;
    f1_nxt.vld  = in_valid;
    f1_nxt.zero = (in_axis_x == 16'sd0) && (in_axis_y == 16'sd0) && (in_axis_z == 16'sd0);
    f1_nxt.vx   = in_axis_x;
    f1_nxt.vy   = in_axis_y;
    f1_nxt.vz   = in_axis_z;
    f1_nxt.num  = 63'(n2);
    if (ang >= TWO_PI_Q30) begin
      f1_nxt.zr = ang - TWO_PI_Q30;
    end else if (ang <= -TWO_PI_Q30) begin
      f1_nxt.zr = ang + TWO_PI_Q30;
    end else begin
      f1_nxt.zr = ang;
    end
  end

  // Stage two: bring the angle into [-pi, pi], find the shift of the length
  always_comb begin
    f2_nxt = f1_r;
    if (f1_r.zr > PI_Q30) begin
      f2_nxt.zr = f1_r.zr - TWO_PI_Q30;
    end else if (f1_r.zr < -PI_Q30) begin
      f2_nxt.zr = f1_r.zr + TWO_PI_Q30;
    end
    f2_nxt.h = '0;
    for (int p = 0; p < 32; p++) begin
      if (f1_r.num[p]) f2_nxt.h = 5'((61 - p) >> 1);
    end
  end

  // Stage three: fold into [-pi/2, pi/2], normalise the length, seed the rotation
  always_comb begin
    f3_nxt     = f2_r;
    f3_nxt.neg = 1'b0;
    if (f2_r.zr > HALF_PI_Q30) begin
      f3_nxt.zr  = PI_Q30 - f2_r.zr;
      f3_nxt.neg = 1'b1;
    end else if (f2_r.zr < -HALF_PI_Q30) begin
      f3_nxt.zr  = -PI_Q30 - f2_r.zr;
      f3_nxt.neg = 1'b1;
    end
    f3_nxt.num = f2_r.num << {f2_r.h, 1'b0};
    f3_nxt.res = '0;
    f3_nxt.cx  = GAIN_Q30;
    f3_nxt.sy  = '0;
  end

  // Advance the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.vld <= 1'b0;
      f2_r.vld <= 1'b0;
      f3_r.vld <= 1'b0;
    end else if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
    end
  end

  assign f_out = f3_r;

endmodule
`default_nettype wire

// File: sv/aar_rot_cell.sv
// Rotation chain cell: one square-root bit, one rotation step unless idx is STEPS.
`timescale 1ns / 1ps
`default_nettype none
module aar_rot_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [4:0] idx,
  input  aar_pkg::rot_t   d_in,
  output aar_pkg::rot_t   d_out
);
  import aar_pkg::*;

  rot_t data_r, data_nxt;

  always_comb begin
    q_t          dx, dy, da;
    logic [62:0] bitv, trial;
    data_nxt = d_in;
    // Rotate towards a zero residual angle
    dx = d_in.sy >>> idx;
    dy = d_in.cx >>> idx;
    da = atan_q30(idx);
    if (idx != 5'(STEPS)) begin
      if (d_in.zr >= 0) begin
        data_nxt.cx = d_in.cx - dx;
        data_nxt.sy = d_in.sy + dy;
        data_nxt.zr = d_in.zr - da;
      end else begin
        data_nxt.cx = d_in.cx + dx;
        data_nxt.sy = d_in.sy - dy;
        data_nxt.zr = d_in.zr + da;
      end
    end
    // Settle one bit of the integer square root
    bitv  = 63'd1 << (6'd60 - {idx, 1'b0});
    trial = d_in.res + bitv;
    if (d_in.num >= trial) begin
      data_nxt.num = d_in.num - trial;
      data_nxt.res = (d_in.res >> 1) + bitv;
    end else begin
      data_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.vld <= 1'b0;
    end else if (en) begin
      data_r <= data_nxt;
    end
  end

  assign d_out = data_r;

endmodule
`default_nettype wire

// File: sv/aar_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the three axis lanes.
`timescale 1ns / 1ps
`default_nettype none
module aar_div_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [4:0] idx,
  input  aar_pkg::div_t   d_in,
  output aar_pkg::div_t   d_out
);
  import aar_pkg::*;

  div_t data_r, data_nxt;

  // Trial-subtract the root shifted to this cell's quotient weight
  always_comb begin
    logic [4:0]  k;
    logic [61:0] d;
    k = 5'(NCELL - 1) - idx;
    d = 62'(d_in.root) << k;
    data_nxt = d_in;
    for (int l = 0; l < 3; l++) begin
      if (d_in.rem[l] >= d) begin
        data_nxt.rem[l] = d_in.rem[l] - d;
        data_nxt.quo[l] = {d_in.quo[l][29:0], 1'b1};
      end else begin
        data_nxt.quo[l] = {d_in.quo[l][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.vld <= 1'b0;
    end else if (en) begin
      data_r <= data_nxt;
    end
  end

  assign d_out = data_r;

endmodule
`default_nettype wire

// File: sv/aar_back.sv
// Back stages: products of the formula, entry sums, rounding and the output register.
`timescale 1ns / 1ps
`default_nettype none
module aar_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  aar_pkg::div_t           d_in,
  input  wire logic               out_ready,
  output logic                    en,
  output logic                    out_valid,
  output logic signed [15:0]      out_r00,
  output logic signed [15:0]      out_r01,
  output logic signed [15:0]      out_r02,
  output logic signed [15:0]      out_r10,
  output logic signed [15:0]      out_r11,
  output logic signed [15:0]      out_r12,
  output logic signed [15:0]      out_r20,
  output logic signed [15:0]      out_r21,
  output logic signed [15:0]      out_r22,
  output logic                    out_zero_axis
);
  import aar_pkg::*;

  typedef struct packed {
    logic vld;
    logic zero;
    q_t   c;
    q_t   t;
    q_t   xx, xy, xz, yy, yz, zz;
    q_t   xs, ys, zs;
  } p1_t;

  typedef struct packed {
    logic vld;
    logic zero;
    q_t   c;
    q_t   xxt, xyt, xzt, yyt, yzt, zzt;
    q_t   xs, ys, zs;
  } p2_t;

  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;

  logic                   out_valid_r;
  logic                   hold;
  logic signed [8:0][15:0] ent_r, ent_nxt;
  logic                   zero_r;

  // Signed unit component from a quotient
  function automatic q_t unit_of(input logic [30:0] q, input logic neg);
    logic [30:0] qc;
    qc = (q > 31'(Q30_ONE)) ? 31'(Q30_ONE) : q;
    return neg ? -q_t'({3'b000, qc}) : q_t'({3'b000, qc});
  endfunction

  // First products: axis pairs and axis times sine
  always_comb begin
    q_t x, y, z;
    x = unit_of(d_in.quo[0], d_in.sgn[0]);
    y = unit_of(d_in.quo[1], d_in.sgn[1]);
    z = unit_of(d_in.quo[2], d_in.sgn[2]);
    p1_nxt.vld  = d_in.vld;
    p1_nxt.zero = d_in.zero;
    p1_nxt.c    = d_in.c;
    p1_nxt.t    = Q30_ONE - d_in.c;
    p1_nxt.xx   = mulq(x, x);
    p1_nxt.xy   = mulq(x, y);
    p1_nxt.xz   = mulq(x, z);
    p1_nxt.yy   = mulq(y, y);
    p1_nxt.yz   = mulq(y, z);
    p1_nxt.zz   = mulq(z, z);
    p1_nxt.xs   = mulq(x, d_in.s);
    p1_nxt.ys   = mulq(y, d_in.s);
    p1_nxt.zs   = mulq(z, d_in.s);
  end

  // Second products: pairs times one minus cosine
  always_comb begin
    p2_nxt.vld  = p1_r.vld;
    p2_nxt.zero = p1_r.zero;
    p2_nxt.c    = p1_r.c;
    p2_nxt.xxt  = mulq(p1_r.xx, p1_r.t);
    p2_nxt.xyt  = mulq(p1_r.xy, p1_r.t);
    p2_nxt.xzt  = mulq(p1_r.xz, p1_r.t);
    p2_nxt.yyt  = mulq(p1_r.yy, p1_r.t);
    p2_nxt.yzt  = mulq(p1_r.yz, p1_r.t);
    p2_nxt.zzt  = mulq(p1_r.zz, p1_r.t);
    p2_nxt.xs   = p1_r.xs;
    p2_nxt.ys   = p1_r.ys;
    p2_nxt.zs   = p1_r.zs;
  end

  // Sum the entries, round and saturate; a zero axis gives zero entries
  always_comb begin
    ent_nxt[0] = to_out(p2_r.c + p2_r.xxt);
    ent_nxt[1] = to_out(p2_r.xyt - p2_r.zs);
    ent_nxt[2] = to_out(p2_r.xzt + p2_r.ys);
    ent_nxt[3] = to_out(p2_r.xyt + p2_r.zs);
    ent_nxt[4] = to_out(p2_r.c + p2_r.yyt);
    ent_nxt[5] = to_out(p2_r.yzt - p2_r.xs);
    ent_nxt[6] = to_out(p2_r.xzt - p2_r.ys);
    ent_nxt[7] = to_out(p2_r.yzt + p2_r.xs);
    ent_nxt[8] = to_out(p2_r.c + p2_r.zzt);
    if (p2_r.zero) ent_nxt = '0;
  end

  // Hold the output word while the receiver stalls; stop the pipe only when
  // a finished word would otherwise be pushed into a full output register
  assign hold = out_valid_r && !out_ready;
  assign en   = !(hold && p2_r.vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.vld    <= 1'b0;
      p2_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        p1_r <= p1_nxt;
        p2_r <= p2_nxt;
      end
      if (!hold) begin
        out_valid_r <= p2_r.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      ent_r  <= ent_nxt;
      zero_r <= p2_r.zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r00       = ent_r[0];
  assign out_r01       = ent_r[1];
  assign out_r02       = ent_r[2];
  assign out_r10       = ent_r[3];
  assign out_r11       = ent_r[4];
  assign out_r12       = ent_r[5];
  assign out_r20       = ent_r[6];
  assign out_r21       = ent_r[7];
  assign out_r22       = ent_r[8];
  assign out_zero_axis = zero_r;

endmodule
`default_nettype wire

// File: sv/axis_angle_rotation_matrix.sv
// Top level: 3x3 rotation matrix from an angle and an axis of any nonzero length.
//
// Input word: angle and axis x, y, z, signed Q4.12, on in_valid / in_ready.
// Output word: nine entries r00..r22, signed Q2.14 saturated to plus or minus
// one, and zero_axis, on out_valid / out_ready. A zero axis sets zero_axis and
// gives zero entries.
// Throughput: one word per cycle unless a stalled output word holds the pipe.
// Path from acceptance to out_valid: 3 front stages, a row of 31 cells that
// runs the angle rotation and the square root of the squared length side by
// side, a row of 31 divider cells that forms the unit axis one quotient bit a
// cell, 2 product stages and the output register.
// The output register holds its word while out_ready is low; the pipe keeps
// moving and taking input until a finished word reaches it, and only then
// does in_ready drop.
// Reset (rst_n low, synchronous) empties every stage; words in flight are dropped
// and none is produced across it. Words carry no state between them.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_rotation_matrix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_angle,
  input  wire logic signed [15:0] in_axis_x,
  input  wire logic signed [15:0] in_axis_y,
  input  wire logic signed [15:0] in_axis_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_r00,
  output logic signed [15:0]      out_r01,
  output logic signed [15:0]      out_r02,
  output logic signed [15:0]      out_r10,
  output logic signed [15:0]      out_r11,
  output logic signed [15:0]      out_r12,
  output logic signed [15:0]      out_r20,
  output logic signed [15:0]      out_r21,
  output logic signed [15:0]      out_r22,
  output logic                    out_zero_axis
);
  import aar_pkg::*;

  logic en;
  rot_t rot_q [0:NCELL];
  div_t div_q [0:NCELL];

  assign in_ready = en;

  aar_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_angle  (in_angle),
    .in_axis_x (in_axis_x),
    .in_axis_y (in_axis_y),
    .in_axis_z (in_axis_z),
    .f_out     (rot_q[0])
  );

  // Rotation and square-root chain
  for (genvar g = 0; g < NCELL; g++) begin : g_rot
    aar_rot_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (5'(g)),
      .d_in  (rot_q[g]),
      .d_out (rot_q[g + 1])
    );
  end

  // Turn the rotation result into divider operands
  always_comb begin
    rot_t                      r;
    logic signed [2:0][15:0]   v;
    logic [15:0]               mag;
    r = rot_q[NCELL];
    v[0] = r.vx;
    v[1] = r.vy;
    v[2] = r.vz;
    div_q[0].vld  = r.vld;
    div_q[0].zero = r.zero;
    div_q[0].c    = clamp_one(r.neg ? -r.cx : r.cx);
    div_q[0].s    = clamp_one(r.sy);
    div_q[0].root = r.res[30:0];
    for (int l = 0; l < 3; l++) begin
      mag = v[l][15] ? 16'(-v[l]) : 16'(v[l]);
      div_q[0].sgn[l] = v[l][15];
      div_q[0].rem[l] = ((62'(mag) << r.h) << 30) + 62'(r.res[30:1]);
      div_q[0].quo[l] = '0;
    end
  end

  // Divider chain
  for (genvar g = 0; g < NCELL; g++) begin : g_div
    aar_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (5'(g)),
      .d_in  (div_q[g]),
      .d_out (div_q[g + 1])
    );
  end

  aar_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .d_in          (div_q[NCELL]),
    .out_ready     (out_ready),
    .en            (en),
    .out_valid     (out_valid),
    .out_r00       (out_r00),
    .out_r01       (out_r01),
    .out_r02       (out_r02),
    .out_r10       (out_r10),
    .out_r11       (out_r11),
    .out_r12       (out_r12),
    .out_r20       (out_r20),
    .out_r21       (out_r21),
    .out_r22       (out_r22),
    .out_zero_axis (out_zero_axis)
  );

  // The input side only stalls behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled output word");

  // A zero axis yields an all-zero matrix
  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_axis) |->
      (out_r00 == 16'sd0 && out_r01 == 16'sd0 && out_r02 == 16'sd0 &&
       out_r10 == 16'sd0 && out_r11 == 16'sd0 && out_r12 == 16'sd0 &&
       out_r20 == 16'sd0 && out_r21 == 16'sd0 && out_r22 == 16'sd0))
    else $error("zero axis with nonzero entries");

  // Diagonal entries stay within plus or minus one after saturation
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r00 <= 16'sd16384 && out_r00 >= -16'sd16384 &&
                   out_r11 <= 16'sd16384 && out_r11 >= -16'sd16384 &&
                   out_r22 <= 16'sd16384 && out_r22 >= -16'sd16384))
    else $error("diagonal entry outside plus or minus one");

  // Reset leaves no word at the output
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output word present after reset");

endmodule
`default_nettype wire
